// File: hdl/jsdp_pkg.sv
// Shared types and constants for the JPEG SOF0 dimension parser.
// No dependencies; compiled first.
package jsdp_pkg;

  // Marker and code bytes
  localparam logic [7:0] MK_FILL   = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST_LO = 8'hD0;
  localparam logic [7:0] MK_RST_HI = 8'hD7;
  localparam logic [7:0] MK_SOF0   = 8'hC0;

  // Segment lengths and body offsets
  localparam logic [15:0] SEG_MIN_LEN   = 16'd2;
  localparam logic [15:0] SOF_MIN_LEN   = 16'd8;
  localparam logic [15:0] IDX_HEIGHT_HI = 16'd3;
  localparam logic [15:0] IDX_HEIGHT_LO = 16'd4;
  localparam logic [15:0] IDX_WIDTH_HI  = 16'd5;
  localparam logic [15:0] IDX_WIDTH_LO  = 16'd6;

  // Buffer must hold at least this many bytes
  localparam logic [2:0] MIN_BYTES = 3'd4;

  // Status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NO_SOI = 2'd1;
  localparam logic [1:0] ST_NO_HDR = 2'd2;

  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_SCAN,
    PH_FILL,
    PH_LENH,
    PH_LENL,
    PH_BODY
  } jsdp_phase_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } jsdp_result_t;

endpackage

// File: hdl/jsdp_if.sv
// Valid/ready channel interfaces for the byte input and the status output.
// Depends on nothing; compiled after jsdp_pkg.
interface jsdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jsdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  modport source (output valid, output status, output frame_width, output frame_height,
                  input ready);
  modport sink   (input valid, input status, input frame_width, input frame_height,
                  output ready);
endinterface

// File: hdl/jsdp_parser.sv
// Per-byte marker grammar: parse state registers plus the combinational step.
// Depends on jsdp_pkg.
module jsdp_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output jsdp_pkg::jsdp_result_t result
);
  import jsdp_pkg::*;

  jsdp_phase_t phase_r, phase_nxt;
  logic [2:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic [15:0] seg_idx_r, seg_idx_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;
  logic        answered_r, answered_nxt;

  logic        decided;
  logic [1:0]  dec_status;
  logic [15:0] len_full;
  logic [16:0] idx_inc;
  logic        seg_end;
  logic        is_standalone;
  logic [2:0]  seen_inc;
  logic [15:0] height_cap;
  logic [15:0] width_cap;

  assign len_full      = {seg_len_r[15:8], data_byte};
  assign idx_inc       = {1'b0, seg_idx_r} + 17'd1;
  assign seg_end       = idx_inc >= {1'b0, seg_len_r};
  assign is_standalone = (data_byte == MK_TEM) ||
                         (data_byte >= MK_RST_LO && data_byte <= MK_RST_HI);
  // byte count including this beat, before any end-of-buffer clear
  assign seen_inc      = (bytes_seen_r < MIN_BYTES) ? bytes_seen_r + 3'd1 : bytes_seen_r;

  // Dimensions including this byte, before any end-of-buffer clear
  always_comb begin
    height_cap = height_r;
    width_cap  = width_r;
    if (!answered_r && phase_r == PH_BODY) begin
      unique case (seg_idx_r)
        IDX_HEIGHT_HI: height_cap = {data_byte, 8'h00};
        IDX_HEIGHT_LO: height_cap = {height_r[15:8], data_byte};
        IDX_WIDTH_HI:  width_cap  = {data_byte, 8'h00};
        IDX_WIDTH_LO:  width_cap  = {width_r[15:8], data_byte};
        default: ;
      endcase
    end
  end

  // Decision for the current byte
  always_comb begin
    decided    = 1'b0;
    dec_status = ST_NO_HDR;
    if (!answered_r) begin
      unique case (phase_r)
        PH_SOI0: begin
          if (data_byte != MK_FILL) begin
            decided    = 1'b1;
            dec_status = ST_NO_SOI;
          end
        end
        PH_SOI1: begin
          if (data_byte != MK_SOI) begin
            decided    = 1'b1;
            dec_status = ST_NO_SOI;
          end
        end
        PH_FILL: begin
          decided = (data_byte == MK_EOI) || (data_byte == MK_SOS);
        end
        PH_LENL: begin
          decided = len_full < SEG_MIN_LEN;
        end
        PH_BODY: begin
          // width_cap/height_cap already include this byte
          if (seg_end && marker_r == MK_SOF0 && seg_len_r >= SOF_MIN_LEN) begin
            decided    = 1'b1;
            dec_status = (width_cap != '0 && height_cap != '0) ? ST_FOUND : ST_NO_HDR;
          end
        end
        default: decided = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    bytes_seen_nxt = bytes_seen_r;
    marker_nxt     = marker_r;
    seg_len_nxt    = seg_len_r;
    seg_idx_nxt    = seg_idx_r;
    height_nxt     = height_r;
    width_nxt      = width_r;
    answered_nxt   = answered_r;
    if (!answered_r) begin
      bytes_seen_nxt = seen_inc;
      unique case (phase_r)
        PH_SOI0: if (data_byte == MK_FILL) phase_nxt = PH_SOI1;
        PH_SOI1: if (data_byte == MK_SOI)  phase_nxt = PH_SCAN;
        PH_SCAN: if (data_byte == MK_FILL) phase_nxt = PH_FILL;
        PH_FILL: begin
          if (data_byte != MK_FILL && data_byte != MK_EOI && data_byte != MK_SOS) begin
            if (is_standalone) begin
              phase_nxt = PH_SCAN;
            end else begin
              marker_nxt = data_byte;
              phase_nxt  = PH_LENH;
            end
          end
        end
        PH_LENH: begin
          seg_len_nxt = {data_byte, 8'h00};
          phase_nxt   = PH_LENL;
        end
        PH_LENL: begin
          seg_len_nxt = len_full;
          if (len_full == SEG_MIN_LEN) begin
            phase_nxt = PH_SCAN;
          end else if (len_full > SEG_MIN_LEN) begin
            seg_idx_nxt = SEG_MIN_LEN;
            phase_nxt   = PH_BODY;
          end
        end
        PH_BODY: begin
          height_nxt = height_cap;
          width_nxt  = width_cap;
          if (seg_end) begin
            if (!(marker_r == MK_SOF0 && seg_len_r >= SOF_MIN_LEN)) phase_nxt = PH_SCAN;
          end else begin
            seg_idx_nxt = idx_inc[15:0];
          end
        end
        default: phase_nxt = PH_SOI0;
      endcase
      if (decided) answered_nxt = 1'b1;
    end
    if (last_byte) begin
      phase_nxt      = PH_SOI0;
      bytes_seen_nxt = '0;
      marker_nxt     = '0;
      seg_len_nxt    = '0;
      seg_idx_nxt    = '0;
      height_nxt     = '0;
      width_nxt      = '0;
      answered_nxt   = 1'b0;
    end
  end

  // Result for this beat
  always_comb begin
    result = '0;
    if (!answered_r) begin
      if (decided) begin
        result.valid  = 1'b1;
        result.status = dec_status;
        if (dec_status == ST_FOUND) begin
          result.frame_width  = width_cap;
          result.frame_height = height_cap;
        end
      end else if (last_byte) begin
        result.valid  = 1'b1;
        result.status = (seen_inc < MIN_BYTES) ? ST_NO_SOI : ST_NO_HDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SOI0;
      bytes_seen_r <= '0;
      marker_r     <= '0;
      seg_len_r    <= '0;
      seg_idx_r    <= '0;
      height_r     <= '0;
      width_r      <= '0;
      answered_r   <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      marker_r     <= marker_nxt;
      seg_len_r    <= seg_len_nxt;
      seg_idx_r    <= seg_idx_nxt;
      height_r     <= height_nxt;
      width_r      <= width_nxt;
      answered_r   <= answered_nxt;
    end
  end

endmodule

// File: hdl/jpeg_sof0_dimension_parser_top.sv
// Top level: input register, parser step, result register.
// Depends on jsdp_pkg, jsdp_if and jsdp_parser.

// Takes one byte of a JPEG buffer per beat, last_byte marking the buffer's
// end, and returns one status beat per buffer: 0 with the SOF0 width and
// height, 1 for a missing FF D8 start or a buffer under four bytes, 2 when
// no usable baseline header was found. It sustains one byte per clock while
// the status output is not held back; a byte's status, if any, passes from
// the input register into the result register once its beat is accepted,
// and is presented there until it is taken.
// While a status waits unaccepted in the result register, the input
// register still takes one byte and then input is held back until the
// status is taken.
module jpeg_sof0_dimension_parser_top (
  input  logic            clk,
  input  logic            rst_n,
  jsdp_in_if.sink         in_chan,
  jsdp_out_if.source      out_chan
);
  import jsdp_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         out_valid_r;
  logic [1:0]   out_status_r;
  logic [15:0]  out_width_r;
  logic [15:0]  out_height_r;
  logic         advance;
  jsdp_result_t step_res;

  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;

  jsdp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_status_r <= step_res.status;
      out_width_r  <= step_res.frame_width;
      out_height_r <= step_res.frame_height;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.frame_width  = out_width_r;
  assign out_chan.frame_height = out_height_r;

`ifndef SYNTHESIS
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FOUND |-> out_width_r != '0 && out_height_r != '0)
    else $error("found status with zero dimension");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_FOUND |-> out_width_r == '0 && out_height_r == '0)
    else $error("failure status with nonzero dimension");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r == ST_FOUND || out_status_r == ST_NO_SOI ||
                    out_status_r == ST_NO_HDR)
    else $error("undefined status code");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_status_r))
    else $error("pending status lost");
`endif

endmodule
